// ===== sv/lfu_oldest_tiebreak_slot_table_assert.svh =====
// assertion macros for the lfu slot table
`ifndef LFU_OLDEST_TIEBREAK_SLOT_TABLE_ASSERT_SVH
`define LFU_OLDEST_TIEBREAK_SLOT_TABLE_ASSERT_SVH

// condition holds at every clock out of reset
`define LFU_OT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LFU_OT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/lfu_ot_pkg.sv =====
// shared constants for the lfu slot table
`default_nettype none

package lfu_ot_pkg;

    localparam int SLOTS_DEF      = 32;
    localparam int ID_BITS_DEF    = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_BITS = 6;
    localparam logic [CFG_BITS-1:0] CFG_LIMIT_RESET = 6'd32;

endpackage

`default_nettype wire

// ===== sv/lfu_oldest_tiebreak_slot_table.sv =====
// lfu slot table with oldest-first tie-break on eviction
//
// s_ channel: one identifier per transaction (s_candidate_id). m_ channel: one
// result per input transaction: hit flag, slot, count after the reference, and
// the evicted identifier if an entry had to make room. cfg_we/cfg_wdata set the
// number of slots that may fill before eviction starts; write it only while
// the block is idle.
// A transaction reads slot 0 in the accept cycle, the other slots in the scan
// state, then passes the last and decide states. The table memory delivers one
// slot per cycle and every reference scans all slots for a match, the least-used
// entry and the first free slot. s_ready is high between transactions; one item
// is in work at a time, so the next is taken once the last result is registered.
// The result sits in an output register, so the next transaction is taken
// while m_ready is low; its scan runs, and its result waits in a holding
// register until the output register empties, with s_ready low meanwhile.
// Reset empties the table at once (valid bits in flops, no clearing pass) and
// sets the limit to 32.
`default_nettype none

`include "lfu_oldest_tiebreak_slot_table_assert.svh"

module lfu_oldest_tiebreak_slot_table #(
    parameter int SLOTS      = lfu_ot_pkg::SLOTS_DEF,
    parameter int ID_BITS    = lfu_ot_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = lfu_ot_pkg::COUNT_BITS_DEF
) (
    input  wire                                          aclk,
    input  wire                                          aresetn,
    input  wire                                          cfg_we,
    input  wire  [lfu_ot_pkg::CFG_BITS-1:0]              cfg_wdata,
    input  wire                                          s_valid,
    output logic                                         s_ready,
    input  wire  [ID_BITS-1:0]                           s_candidate_id,
    output logic                                         m_valid,
    input  wire                                          m_ready,
    output logic                                         m_hit,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] m_slot_index,
    output logic [COUNT_BITS-1:0]                        m_new_count,
    output logic                                         m_evicted,
    output logic [ID_BITS-1:0]                           m_evicted_id
);

    import lfu_ot_pkg::*;

    localparam int IDX_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RANK_BITS = $clog2(SLOTS + 1);
    localparam int WORD_BITS = ID_BITS + COUNT_BITS + RANK_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    ident;
        logic [COUNT_BITS-1:0] refs;
        logic [RANK_BITS-1:0]  rank;
    } entry_t;

    typedef struct packed {
        logic                  hit;
        logic [IDX_BITS-1:0]   slot;
        logic [COUNT_BITS-1:0] count;
        logic                  evicted;
        logic [ID_BITS-1:0]    evicted_id;
    } result_t;

    // control state
    state_t                state_reg, state_next;
    logic [CFG_BITS-1:0]   cfg_limit_reg, cfg_limit_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [RANK_BITS-1:0]  occ_reg, occ_next;
    logic                  pend_reg, pend_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  found_reg, found_next;
    logic                  min_vld_reg, min_vld_next;
    logic                  free_vld_reg, free_vld_next;
    logic                  m_valid_reg, m_valid_next;

    // payload
    logic [RANK_BITS-1:0]  pend_rank_reg, pend_rank_next;
    logic [IDX_BITS-1:0]   scan_addr_reg, scan_addr_next;
    logic [IDX_BITS-1:0]   rd_idx_reg, rd_idx_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [IDX_BITS-1:0]   found_idx_reg, found_idx_next;
    logic [COUNT_BITS-1:0] found_refs_reg, found_refs_next;
    logic [RANK_BITS-1:0]  found_rank_reg, found_rank_next;
    logic [IDX_BITS-1:0]   min_idx_reg, min_idx_next;
    logic [COUNT_BITS-1:0] min_refs_reg, min_refs_next;
    logic [RANK_BITS-1:0]  min_rank_reg, min_rank_next;
    logic [ID_BITS-1:0]    min_ident_reg, min_ident_next;
    logic [IDX_BITS-1:0]   free_idx_reg, free_idx_next;
    result_t               hold_reg, hold_next;
    result_t               out_reg, out_next;

    logic                  accept;
    logic                  out_free;
    logic [IDX_BITS-1:0]   rd_addr;
    logic [WORD_BITS-1:0]  rd_data;
    entry_t                rd_word;
    logic                  ent_valid;
    logic                  dec;
    logic [RANK_BITS-1:0]  adj_rank;
    logic [RANK_BITS-1:0]  eff_limit;
    logic                  evict;
    logic [COUNT_BITS-1:0] inc_refs;
    result_t               res;
    entry_t                upd_word;
    entry_t                wb_word;
    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_hit        = out_reg.hit;
    assign m_slot_index = out_reg.slot;
    assign m_new_count  = out_reg.count;
    assign m_evicted    = out_reg.evicted;
    assign m_evicted_id = out_reg.evicted_id;

    // slot 0 is read in the accept cycle, the rest during the scan
    assign rd_addr = (state_reg == S_SCAN) ? scan_addr_reg : '0;
    assign rd_word = entry_t'(rd_data);
    assign ent_valid = valid_reg[rd_idx_reg];

    // close up the ranks left open by the previous eviction
    assign dec      = pend_reg && (rd_word.rank > pend_rank_reg);
    assign adj_rank = dec ? rd_word.rank - RANK_BITS'(1) : rd_word.rank;

    always_comb begin
        if (cfg_limit_reg == '0) begin
            eff_limit = RANK_BITS'(1);
        end else if (int'(cfg_limit_reg) > SLOTS) begin
            eff_limit = RANK_BITS'(SLOTS);
        end else begin
            eff_limit = RANK_BITS'(cfg_limit_reg);
        end
    end

    assign evict    = !found_reg && min_vld_reg && (occ_reg >= eff_limit);
    assign inc_refs = (&found_refs_reg) ? found_refs_reg
                                        : found_refs_reg + COUNT_BITS'(1);

    always_comb begin
        res.hit        = found_reg;
        res.slot       = found_reg ? found_idx_reg : (evict ? min_idx_reg : free_idx_reg);
        res.count      = found_reg ? inc_refs : COUNT_BITS'(1);
        res.evicted    = evict;
        res.evicted_id = evict ? min_ident_reg : '0;
    end

    // new entries take the current occupancy as rank; after an eviction that
    // is one above the dense rank and the next scan brings it down
    always_comb begin
        upd_word.ident = id_reg;
        upd_word.refs  = res.count;
        upd_word.rank  = found_reg ? found_rank_reg : occ_reg;
        wb_word        = rd_word;
        wb_word.rank   = adj_rank;
    end

    always_comb begin
        if (state_reg == S_DECIDE) begin
            ram_we    = 1'b1;
            ram_waddr = res.slot;
            ram_wdata = upd_word;
        end else begin
            ram_we    = rd_vld_reg && ent_valid && dec;
            ram_waddr = rd_idx_reg;
            ram_wdata = wb_word;
        end
    end

    lfu_ot_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        cfg_limit_next  = cfg_we ? cfg_wdata : cfg_limit_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        pend_next       = pend_reg;
        pend_rank_next  = pend_rank_reg;
        scan_addr_next  = scan_addr_reg;
        rd_vld_next     = accept || (state_reg == S_SCAN);
        rd_idx_next     = rd_addr;
        id_next         = id_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_refs_next = found_refs_reg;
        found_rank_next = found_rank_reg;
        min_vld_next    = min_vld_reg;
        min_idx_next    = min_idx_reg;
        min_refs_next   = min_refs_reg;
        min_rank_next   = min_rank_reg;
        min_ident_next  = min_ident_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    id_next        = s_candidate_id;
                    found_next     = 1'b0;
                    min_vld_next   = 1'b0;
                    free_vld_next  = 1'b0;
                    scan_addr_next = IDX_BITS'(1);
                    state_next     = (SLOTS == 1) ? S_LAST : S_SCAN;
                end
            end
            S_SCAN: begin
                scan_addr_next = scan_addr_reg + IDX_BITS'(1);
                if (scan_addr_reg == LAST_IDX) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                // the scan has applied any pending rank close-up
                pend_next      = evict;
                pend_rank_next = min_rank_reg;
                if (!found_reg && !evict) begin
                    valid_next[free_idx_reg] = 1'b1;
                    occ_next                 = occ_reg + RANK_BITS'(1);
                end
                if (out_free) begin
                    out_next     = res;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    hold_next  = res;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_next     = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // one slot arrives from the table per cycle during the scan
        if (rd_vld_reg) begin
            if (ent_valid && (rd_word.ident == id_reg) && !found_reg) begin
                found_next      = 1'b1;
                found_idx_next  = rd_idx_reg;
                found_refs_next = rd_word.refs;
                found_rank_next = adj_rank;
            end
            if (ent_valid && (!min_vld_reg || (rd_word.refs < min_refs_reg) ||
                              ((rd_word.refs == min_refs_reg) &&
                               (adj_rank < min_rank_reg)))) begin
                min_vld_next   = 1'b1;
                min_idx_next   = rd_idx_reg;
                min_refs_next  = rd_word.refs;
                min_rank_next  = adj_rank;
                min_ident_next = rd_word.ident;
            end
            if (!ent_valid && !free_vld_reg) begin
                free_vld_next = 1'b1;
                free_idx_next = rd_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_rank_reg  <= pend_rank_next;
        scan_addr_reg  <= scan_addr_next;
        rd_idx_reg     <= rd_idx_next;
        id_reg         <= id_next;
        found_idx_reg  <= found_idx_next;
        found_refs_reg <= found_refs_next;
        found_rank_reg <= found_rank_next;
        min_idx_reg    <= min_idx_next;
        min_refs_reg   <= min_refs_next;
        min_rank_reg   <= min_rank_next;
        min_ident_reg  <= min_ident_next;
        free_idx_reg   <= free_idx_next;
        hold_reg       <= hold_next;
        out_reg        <= out_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cfg_limit_reg <= CFG_LIMIT_RESET;
            valid_reg     <= '0;
            occ_reg       <= '0;
            pend_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            min_vld_reg   <= 1'b0;
            free_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cfg_limit_reg <= cfg_limit_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            pend_reg      <= pend_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            min_vld_reg   <= min_vld_next;
            free_vld_reg  <= free_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    `LFU_OT_ASSERT_ALWAYS(a_occ_matches_valid, $countones(valid_reg) == int'(occ_reg), "occupancy off")
    `LFU_OT_ASSERT_IMPLY(a_update_no_scan_write, state_reg == S_DECIDE, !rd_vld_reg, "update in scan")
    `LFU_OT_ASSERT_IMPLY(a_miss_count_one, m_valid && !m_hit, m_new_count == COUNT_BITS'(1), "miss count")
    `LFU_OT_ASSERT_IMPLY(a_evict_on_miss_only, m_valid && m_evicted, !m_hit, "eviction on a hit")

endmodule

`default_nettype wire

// ===== sv/lfu_ot_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module lfu_ot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                                            clk,
    input  wire                                            we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire  [WIDTH-1:0]                               wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
